// File: src/mpwbs_pkg.sv
// Shared constants, codes and types of the wildcard byte pattern scanner.
package mpwbs_pkg;

	localparam int MAX_PATTERNS    = 4;
	localparam int MAX_PATTERN_LEN = 16;
	localparam int WINDOW_DEPTH    = 64;

	localparam int SEL_W  = $clog2(MAX_PATTERNS);
	localparam int POS_W  = $clog2(MAX_PATTERN_LEN);
	localparam int LEN_W  = 5;
	localparam int OFF_W  = 6;
	localparam int IDX_W  = $clog2(WINDOW_DEPTH);
	localparam int SPAN_W = 7;
	localparam int CNT_W  = 3;
	localparam int ADDR_W = 32;

	// Wildcard pattern byte values ('*' and '?')
	localparam logic [7:0] WILD_STAR  = 8'h2A;
	localparam logic [7:0] WILD_QUERY = 8'h3F;

	// Command codes carried in s_tuser
	typedef enum logic [1:0] {
		CMD_PAT_BYTE = 2'd0,
		CMD_PAT_HDR  = 2'd1,
		CMD_MEM_BYTE = 2'd2,
		CMD_END      = 2'd3
	} cmd_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_PAT_COUNT  = 3'd0,
		REG_SPAN       = 3'd1,
		REG_SCAN_BEGIN = 3'd2,
		REG_SCAN_END   = 3'd3,
		REG_RES_OFFSET = 3'd4
	} reg_idx_t;

	typedef logic [MAX_PATTERN_LEN-1:0][7:0] pat_row_t;

	// One pattern as seen by the window cells
	typedef struct packed {
		logic              active;
		logic [LEN_W-1:0]  len;
		logic [OFF_W-1:0]  off;
		pat_row_t          bytes;
	} pat_entry_t;

	typedef pat_entry_t [MAX_PATTERNS-1:0] pat_set_t;

	// Pattern table write request
	typedef struct packed {
		logic              byte_we;
		logic              hdr_we;
		logic [SEL_W-1:0]  sel;
		logic [POS_W-1:0]  pos;
		logic [7:0]        data;
		logic [LEN_W-1:0]  len;
		logic [OFF_W-1:0]  off;
	} pat_wr_t;

	// Per-cell compare status
	typedef struct packed {
		logic ok;
		logic start_ok;
	} cell_stat_t;

endpackage

// File: src/mpwbs_pattern_table.sv
// Pattern table: bytes, lengths and offsets, plus the per-pattern span check.
module mpwbs_pattern_table (
	input  logic                              clk,
	input  mpwbs_pkg::pat_wr_t                wr,
	input  logic [mpwbs_pkg::CNT_W-1:0]       pat_count,
	input  logic [mpwbs_pkg::SPAN_W-1:0]      span_eff,
	output mpwbs_pkg::pat_set_t               pats,
	output logic                              over_span
);
	import mpwbs_pkg::*;

	pat_row_t              bytes_q [MAX_PATTERNS];
	logic [LEN_W-1:0]      len_q   [MAX_PATTERNS];
	logic [OFF_W-1:0]      off_q   [MAX_PATTERNS];
	logic [MAX_PATTERNS-1:0] past_span;

	// Table writes; lengths saturate at the row size
	always_ff @(posedge clk) begin
		if (wr.byte_we) begin
			bytes_q[wr.sel][wr.pos] <= wr.data;
		end
		if (wr.hdr_we) begin
			if (wr.len > LEN_W'(MAX_PATTERN_LEN)) begin
				len_q[wr.sel] <= LEN_W'(MAX_PATTERN_LEN);
			end else begin
				len_q[wr.sel] <= wr.len;
			end
			off_q[wr.sel] <= wr.off;
		end
	end

	// Active patterns and those that reach beyond the span
	always_comb begin
		for (int p = 0; p < MAX_PATTERNS; p++) begin
			pats[p].active = (CNT_W'(p) < pat_count) && (len_q[p] != '0);
			pats[p].len    = len_q[p];
			pats[p].off    = off_q[p];
			pats[p].bytes  = bytes_q[p];
			past_span[p]   = pats[p].active &&
				(({1'b0, off_q[p]} + SPAN_W'(len_q[p])) > span_eff);
		end
	end

	assign over_span = |past_span;

endmodule

// File: src/mpwbs_cell.sv
// One window cell: holds a byte and its valid flag and checks it against the patterns.
module mpwbs_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift,
	input  logic                          clear,
	input  logic [mpwbs_pkg::IDX_W-1:0]   cell_idx,
	input  logic [mpwbs_pkg::SPAN_W-1:0]  span_eff,
	input  mpwbs_pkg::pat_set_t           pats,
	input  logic [7:0]                    prev_byte,
	input  logic                          prev_valid,
	output logic [7:0]                    cur_byte,
	output logic                          cur_valid,
	output mpwbs_pkg::cell_stat_t         stat
);
	import mpwbs_pkg::*;

	logic [7:0]        byte_q;
	logic              valid_q;
	logic              in_span;
	logic [SPAN_W-1:0] dist_w;
	logic [OFF_W-1:0]  dist_ofs;
	logic [OFF_W-1:0]  rel;
	logic [7:0]        expect_byte;
	logic              covers;
	logic              hit;
	logic [MAX_PATTERNS-1:0] fail;

	// Byte payload shifts without reset
	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= prev_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= prev_valid;
		end
	end

	assign cur_byte  = byte_q;
	assign cur_valid = valid_q;

	// Distance from candidate start of the byte this cell holds after the shift
	assign in_span  = {1'b0, cell_idx} < span_eff;
	assign dist_w   = span_eff - SPAN_W'(1) - {1'b0, cell_idx};
	assign dist_ofs = dist_w[OFF_W-1:0];

	// Compare the incoming byte against each pattern that covers this distance
	always_comb begin
		fail        = '0;
		rel         = '0;
		expect_byte = '0;
		covers      = 1'b0;
		hit         = 1'b0;
		for (int p = 0; p < MAX_PATTERNS; p++) begin
			rel         = dist_ofs - pats[p].off;
			covers      = pats[p].active && in_span && (dist_ofs >= pats[p].off) &&
				(rel < OFF_W'(pats[p].len));
			expect_byte = pats[p].bytes[rel[POS_W-1:0]];
			hit         = (expect_byte == WILD_STAR) || (expect_byte == WILD_QUERY) ||
				(expect_byte == prev_byte);
			fail[p]     = covers && !(prev_valid && hit);
		end
	end

	assign stat.ok       = ~|fail;
	assign stat.start_ok = in_span && (dist_ofs == '0) && prev_valid;

endmodule

// File: src/multi_pattern_wildcard_byte_scan.sv
// Top level: multi-pattern wildcard byte scanner over a shifting window of cells.
// A result is in the output register in the cycle after the item that causes it.
// Throughput: one item per cycle; the window of cells shifts and compares in that cycle.
// The input stalls only while a held result is not taken.
// Reset clears window valid flags, the match flag and the output register, and
// loads pattern_count 1, span 1 and zero for the other registers; no clearing pass.
module multi_pattern_wildcard_byte_scan (
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	// [1:0] pattern_select, [5:2] byte_position, [13:6] data_byte,
	// [18:14] pattern_length, [24:19] pattern_offset, [56:25] byte_address,
	// [57] byte_valid, [63:58] zero
	input  logic [63:0] s_tdata,
	// [1:0] command
	input  logic [1:0]  s_tuser,
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	// [31:0] match_address
	output logic [31:0] m_tdata,
	// [0] found
	output logic        m_tuser
);
	import mpwbs_pkg::*;

	logic [CNT_W-1:0]  pat_count_q;
	logic [SPAN_W-1:0] span_q;
	logic [ADDR_W-1:0] scan_begin_q;
	logic [ADDR_W-1:0] scan_end_q;
	logic [ADDR_W-1:0] res_offset_q;
	logic              reported_q;
	logic              out_valid_q;
	logic              out_found_q;
	logic [ADDR_W-1:0] out_addr_q;

	cmd_t              cmd;
	logic              accept;
	logic              mem_acc;
	logic              end_acc;
	logic [SPAN_W-1:0] span_eff;
	logic [ADDR_W-1:0] in_addr;
	logic [ADDR_W-1:0] start_addr;
	logic              in_range;
	logic              all_ok;
	logic              start_ok;
	logic              over_span;
	logic              hit_now;
	pat_wr_t           wr;
	pat_set_t          pats;

	logic [WINDOW_DEPTH-1:0][7:0] win_byte;
	logic [WINDOW_DEPTH-1:0]      win_vld;
	logic [WINDOW_DEPTH-1:0]      ok_vec;
	logic [WINDOW_DEPTH-1:0]      start_vec;

	// Handshakes
	assign cfg_ready = 1'b1;
	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign cmd       = cmd_t'(s_tuser);
	assign mem_acc   = accept && (cmd == CMD_MEM_BYTE);
	assign end_acc   = accept && (cmd == CMD_END);
	assign in_addr   = s_tdata[56:25];

	// Span clamped to 1..WINDOW_DEPTH
	always_comb begin
		if (span_q == '0) begin
			span_eff = SPAN_W'(1);
		end else if (span_q > SPAN_W'(WINDOW_DEPTH)) begin
			span_eff = SPAN_W'(WINDOW_DEPTH);
		end else begin
			span_eff = span_q;
		end
	end

	// Pattern table write request
	assign wr.byte_we = accept && (cmd == CMD_PAT_BYTE);
	assign wr.hdr_we  = accept && (cmd == CMD_PAT_HDR);
	assign wr.sel     = s_tdata[1:0];
	assign wr.pos     = s_tdata[5:2];
	assign wr.data    = s_tdata[13:6];
	assign wr.len     = s_tdata[18:14];
	assign wr.off     = s_tdata[24:19];

	mpwbs_pattern_table u_table (
		.clk       (clk),
		.wr        (wr),
		.pat_count (pat_count_q),
		.span_eff  (span_eff),
		.pats      (pats),
		.over_span (over_span)
	);

	// Row of window cells, newest byte enters cell 0
	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		logic [7:0] prev_byte;
		logic       prev_valid;
		cell_stat_t stat;
		if (i == 0) begin : g_head
			assign prev_byte  = s_tdata[13:6];
			assign prev_valid = s_tdata[57];
		end else begin : g_link
			assign prev_byte  = win_byte[i-1];
			assign prev_valid = win_vld[i-1];
		end
		mpwbs_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (mem_acc),
			.clear      (end_acc),
			.cell_idx   (IDX_W'(i)),
			.span_eff   (span_eff),
			.pats       (pats),
			.prev_byte  (prev_byte),
			.prev_valid (prev_valid),
			.cur_byte   (win_byte[i]),
			.cur_valid  (win_vld[i]),
			.stat       (stat)
		);
		assign ok_vec[i]    = stat.ok;
		assign start_vec[i] = stat.start_ok;
	end

	// Candidate decision
	assign start_addr = in_addr - ADDR_W'(span_eff - SPAN_W'(1));
	assign in_range   = (start_addr >= scan_begin_q) && (start_addr <= scan_end_q);
	assign all_ok     = &ok_vec;
	assign start_ok   = |start_vec;
	assign hit_now    = mem_acc && !reported_q && start_ok && in_range && all_ok &&
		!over_span;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_count_q  <= CNT_W'(1);
			span_q       <= SPAN_W'(1);
			scan_begin_q <= '0;
			scan_end_q   <= '0;
			res_offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PAT_COUNT:  pat_count_q  <= cfg_data[CNT_W-1:0];
				REG_SPAN:       span_q       <= cfg_data[SPAN_W-1:0];
				REG_SCAN_BEGIN: scan_begin_q <= cfg_data;
				REG_SCAN_END:   scan_end_q   <= cfg_data;
				REG_RES_OFFSET: res_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Match flag and output register; a new result replaces one taken in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reported_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			out_addr_q  <= '0;
		end else begin
			if (hit_now) begin
				reported_q  <= 1'b1;
				out_valid_q <= 1'b1;
				out_found_q <= 1'b1;
				out_addr_q  <= start_addr + res_offset_q;
			end else if (end_acc) begin
				reported_q <= 1'b0;
				if (!reported_q) begin
					out_valid_q <= 1'b1;
					out_found_q <= 1'b0;
					out_addr_q  <= '0;
				end else if (m_tvalid && m_tready) begin
					out_valid_q <= 1'b0;
				end
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_addr_q;
	assign m_tuser  = out_found_q;

endmodule

// File: tb/mpwbs_scan_checker.sv
// Scoreboard for the wildcard byte scanner: mirrors the scan state, predicts result words, compares.
module mpwbs_scan_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tuser,
	output int          fail_count,
	output int          open_count,
	output int          hit_count,
	output int          miss_count
);
	import mpwbs_pkg::*;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] addr;
	} scan_res_t;

	// mirrored scan state
	logic [7:0]        win_data [WINDOW_DEPTH];
	logic              win_ok   [WINDOW_DEPTH];
	logic [7:0]        pat_byte [MAX_PATTERNS][MAX_PATTERN_LEN];
	logic [LEN_W-1:0]  pat_len  [MAX_PATTERNS];
	logic [OFF_W-1:0]  pat_off  [MAX_PATTERNS];
	logic              hit_sent;

	// mirrored registers
	logic [CNT_W-1:0]  need_cnt;
	logic [SPAN_W-1:0] span_cfg;
	logic [ADDR_W-1:0] lo_lim;
	logic [ADDR_W-1:0] hi_lim;
	logic [ADDR_W-1:0] res_bias;

	scan_res_t pending_q[$];
	int n_err;
	int n_hit;
	int n_miss;

	task automatic report(input string what);
		n_err++;
		$display("[%0t] scan mismatch: %s", $time, what);
	endtask

	task automatic reset_model();
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			win_data[i] = '0;
			win_ok[i]   = 1'b0;
		end
		// never read before written; zeroed only to keep the arrays known
		for (int p = 0; p < MAX_PATTERNS; p++) begin
			pat_len[p] = '0;
			pat_off[p] = '0;
			for (int k = 0; k < MAX_PATTERN_LEN; k++)
				pat_byte[p][k] = '0;
		end
		hit_sent = 1'b0;
		need_cnt = CNT_W'(1);
		span_cfg = SPAN_W'(1);
		lo_lim   = '0;
		hi_lim   = '0;
		res_bias = '0;
		pending_q.delete();
		n_err  = 0;
		n_hit  = 0;
		n_miss = 0;
	endtask

	// Byte at distance d from the candidate start: arrived, readable, and equal or wildcard
	function automatic logic window_agrees(int s, int d, logic [7:0] pb);
		int idx;
		if (d >= s)
			return 1'b0;
		idx = s - 1 - d;
		if (!win_ok[idx])
			return 1'b0;
		if (pb == WILD_STAR || pb == WILD_QUERY)
			return 1'b1;
		return win_data[idx] == pb;
	endfunction

	function automatic logic all_patterns_hit(int s);
		int n;
		n = (need_cnt > MAX_PATTERNS) ? MAX_PATTERNS : int'(need_cnt);
		for (int p = 0; p < n; p++)
			for (int k = 0; k < pat_len[p]; k++)
				if (!window_agrees(s, pat_off[p] + k, pat_byte[p][k]))
					return 1'b0;
		return 1'b1;
	endfunction

	task automatic take_reg(input reg_idx_t idx, input logic [31:0] v);
		case (idx)
			REG_PAT_COUNT:  need_cnt = v[CNT_W-1:0];
			REG_SPAN:       span_cfg = v[SPAN_W-1:0];
			REG_SCAN_BEGIN: lo_lim   = v;
			REG_SCAN_END:   hi_lim   = v;
			REG_RES_OFFSET: res_bias = v;
			default: ;
		endcase
	endtask

	// One accepted input word; queues the result word it causes, if any
	task automatic step_item(input cmd_t cmd, input logic [63:0] d);
		logic [SEL_W-1:0]  sel;
		logic [POS_W-1:0]  pos;
		logic [7:0]        b;
		logic [LEN_W-1:0]  len;
		logic [OFF_W-1:0]  off;
		logic [ADDR_W-1:0] addr;
		logic              ok;
		logic [ADDR_W-1:0] start;
		int                s;
		sel  = d[1:0];
		pos  = d[5:2];
		b    = d[13:6];
		len  = d[18:14];
		off  = d[24:19];
		addr = d[56:25];
		ok   = d[57];
		case (cmd)
			CMD_PAT_BYTE: begin
				pat_byte[sel][pos] = b;
			end
			CMD_PAT_HDR: begin
				pat_len[sel] = (len > MAX_PATTERN_LEN) ? LEN_W'(MAX_PATTERN_LEN) : len;
				pat_off[sel] = off;
			end
			CMD_END: begin
				if (!hit_sent)
					pending_q.push_back('{found: 1'b0, addr: '0});
				hit_sent = 1'b0;
				for (int i = 0; i < WINDOW_DEPTH; i++)
					win_ok[i] = 1'b0;
			end
			default: begin
				// memory byte: newest at the low end of the window
				for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
					win_data[i] = win_data[i-1];
					win_ok[i]   = win_ok[i-1];
				end
				win_data[0] = b;
				win_ok[0]   = ok;
				if (!hit_sent) begin
					s = (span_cfg == 0) ? 1 :
					    (span_cfg > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(span_cfg);
					start = addr - ADDR_W'(s - 1);
					if (win_ok[s-1] && start >= lo_lim && start <= hi_lim &&
					    all_patterns_hit(s)) begin
						hit_sent = 1'b1;
						pending_q.push_back('{found: 1'b1, addr: start + res_bias});
					end
				end
			end
		endcase
	endtask

	task automatic check_result(input logic found, input logic [31:0] addr);
		scan_res_t want;
		if (pending_q.size() == 0) begin
			report($sformatf("result word found=%b addr=%h with nothing expected", found, addr));
		end else begin
			want = pending_q.pop_front();
			if (want.found) n_hit++;
			else n_miss++;
			if (found !== want.found)
				report($sformatf("found %b, expected %b", found, want.found));
			if (addr !== want.addr)
				report($sformatf("match_address %h, expected %h", addr, want.addr));
		end
	endtask

	// Results are compared before the same edge's input word is folded in
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_model();
			fail_count <= 0;
			open_count <= 0;
			hit_count  <= 0;
			miss_count <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tuser, m_tdata);
			if (cfg_valid && cfg_ready)
				take_reg(reg_idx_t'(cfg_index), cfg_data);
			if (s_tvalid && s_tready)
				step_item(cmd_t'(s_tuser), s_tdata);
			fail_count <= n_err;
			open_count <= pending_q.size();
			hit_count  <= n_hit;
			miss_count <= n_miss;
		end
	end

endmodule

// File: tb/multi_pattern_wildcard_byte_scan_tb.sv
// Testbench top for the wildcard byte scanner: clock, reset, stimulus and verdict.
module multi_pattern_wildcard_byte_scan_tb;
	import mpwbs_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int WORD_TARGET   = 1750;
	localparam int DRAIN_CYCLES  = 4;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;

	int fail_count;
	int open_count;
	int hit_count;
	int miss_count;

	int n_items     = 0;
	int n_setups    = 0;
	int n_cycles    = 0;
	int tx_idle_pct = 8;
	int rx_idle_pct = 46;

	// pattern table and register values as last written, used to plant matches
	logic [7:0]        pat_img [MAX_PATTERNS][MAX_PATTERN_LEN];
	logic [LEN_W-1:0]  hdr_len [MAX_PATTERNS];
	logic [OFF_W-1:0]  hdr_off [MAX_PATTERNS];
	logic [CNT_W-1:0]  cur_cnt  = CNT_W'(1);
	logic [SPAN_W-1:0] cur_span = SPAN_W'(1);

	multi_pattern_wildcard_byte_scan i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	mpwbs_scan_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.open_count (open_count),
		.hit_count  (hit_count),
		.miss_count (miss_count)
	);

	always #10 clk = ~clk;

	// result side stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// run limit
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still open", n_cycles, open_count);
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [63:0] mk_word(input logic [1:0] sel, input logic [3:0] pos,
			input logic [7:0] b, input logic [4:0] len, input logic [5:0] off,
			input logic [31:0] addr, input logic ok);
		return {6'b0, ok, addr, off, len, b, pos, sel};
	endfunction

	function automatic logic [7:0] pick_pat_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return WILD_STAR;
		if (r == 1) return WILD_QUERY;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 2) return $urandom_range(17, 31);
		if (r < 4) return $urandom_range(7, 16);
		return $urandom_range(0, 6);
	endfunction

	function automatic int pick_off();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 63) : $urandom_range(0, 8);
	endfunction

	function automatic int eff_count();
		return (cur_cnt > MAX_PATTERNS) ? MAX_PATTERNS : int'(cur_cnt);
	endfunction

	function automatic int eff_span();
		if (cur_span == 0) return 1;
		return (cur_span > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(cur_span);
	endfunction

	// Input word handshake with random source gaps
	task automatic send_word(input cmd_t cmd, input logic [63:0] data);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		n_items++;
		// slow sink first, then slow source, then full rate
		tx_idle_pct = (n_items < 600) ? 8 : (n_items < 1200) ? 46 : 0;
		rx_idle_pct <= (n_items < 600) ? 46 : (n_items < 1200) ? 8 : 0;
	endtask

	task automatic put_pat_byte(input logic [1:0] sel, input logic [3:0] pos,
			input logic [7:0] b);
		send_word(CMD_PAT_BYTE, mk_word(sel, pos, b, 5'($urandom), 6'($urandom),
			$urandom, 1'($urandom)));
		pat_img[sel][pos] = b;
	endtask

	task automatic put_pat_hdr(input logic [1:0] sel, input logic [4:0] len,
			input logic [5:0] off);
		send_word(CMD_PAT_HDR, mk_word(sel, 4'($urandom), 8'($urandom), len, off,
			$urandom, 1'($urandom)));
		hdr_len[sel] = (len > MAX_PATTERN_LEN) ? LEN_W'(MAX_PATTERN_LEN) : len;
		hdr_off[sel] = off;
	endtask

	task automatic put_mem(input logic [31:0] addr, input logic [7:0] b, input logic ok);
		send_word(CMD_MEM_BYTE, mk_word(2'($urandom), 4'($urandom), b, 5'($urandom),
			6'($urandom), addr, ok));
	endtask

	task automatic put_end();
		send_word(CMD_END, mk_word(2'($urandom), 4'($urandom), 8'($urandom),
			5'($urandom), 6'($urandom), $urandom, 1'($urandom)));
	endtask

	// Bytes go in before the header, so no unwritten byte is ever compared
	task automatic load_pattern(input int sel, input int len, input int off);
		int n;
		n = (len > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : len;
		for (int k = 0; k < n; k++)
			put_pat_byte(2'(sel), 4'(k), pick_pat_byte());
		put_pat_hdr(2'(sel), 5'(len), 6'(off));
	endtask

	// Wait until every expected result word is out, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (open_count != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input logic [2:0] cnt, input logic [6:0] sp,
			input logic [31:0] lo, input logic [31:0] hi, input logic [31:0] bias);
		write_reg(REG_PAT_COUNT, 32'(cnt));
		write_reg(REG_SPAN, 32'(sp));
		write_reg(REG_SCAN_BEGIN, lo);
		write_reg(REG_SCAN_END, hi);
		write_reg(REG_RES_OFFSET, bias);
		cfg_valid <= 1'b0;
		cur_cnt  = cnt;
		cur_span = sp;
		n_setups++;
	endtask

	// One scan: random bytes, usually with every pattern planted at one start
	task automatic run_scan(input logic [31:0] base);
		logic [7:0] mem_b  [0:127];
		logic       mem_ok [0:127];
		int s, cnt, n, plant, bad_pct, poke_at, pos, p;
		bit jumpy;
		s       = eff_span();
		cnt     = eff_count();
		n       = s + $urandom_range(0, 20);
		plant   = ($urandom_range(0, 9) < 7) ? $urandom_range(0, n - s) : -1;
		bad_pct = ($urandom_range(0, 3) == 0) ? 30 : 3;
		jumpy   = ($urandom_range(0, 9) == 0);
		poke_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
		for (int i = 0; i < n; i++) begin
			mem_b[i]  = 8'($urandom_range(0, 255));
			mem_ok[i] = ($urandom_range(99) >= bad_pct);
		end
		if (plant >= 0) begin
			mem_ok[plant] = 1'b1;
			for (int q = 0; q < cnt; q++)
				for (int k = 0; k < hdr_len[q]; k++) begin
					pos = plant + hdr_off[q] + k;
					if (pos < n) begin
						mem_ok[pos] = 1'b1;
						if (pat_img[q][k] != WILD_STAR && pat_img[q][k] != WILD_QUERY)
							mem_b[pos] = pat_img[q][k];
					end
				end
		end
		for (int i = 0; i < n; i++) begin
			// table rewrite in the middle of a scan
			if (i == poke_at) begin
				p = $urandom_range(0, MAX_PATTERNS - 1);
				if ($urandom_range(0, 1))
					put_pat_byte(2'(p), 4'($urandom_range(0, MAX_PATTERN_LEN - 1)),
						pick_pat_byte());
				else
					put_pat_hdr(2'(p), hdr_len[p], 6'($urandom_range(0, 63)));
			end
			put_mem((jumpy && $urandom_range(0, 9) == 0) ? $urandom : base + i,
				mem_b[i], mem_ok[i]);
		end
		if ($urandom_range(0, 19) != 0)
			put_end();
	endtask

	// New patterns, a new register setup, then a few scans
	task automatic run_phase(input int idx);
		int cnt, need, sp, r, nscan;
		logic [31:0] rbase, lo, hi, bias;
		for (int i = 0; i < MAX_PATTERNS; i++)
			if (idx == 0 ? i == 0 : $urandom_range(0, 2) == 0) begin
				if (idx == 0) load_pattern(i, 31, 48);
				else if (idx == 1 && i == MAX_PATTERNS - 1) load_pattern(i, 16, 0);
				else load_pattern(i, pick_len(), pick_off());
			end
		if (idx == 1)
			load_pattern(MAX_PATTERNS - 1, 16, 0);

		r = $urandom_range(0, 9);
		if (idx == 0) cnt = 7;
		else if (idx == 1) cnt = MAX_PATTERNS;
		else if (r == 0) cnt = 0;
		else if (r == 1) cnt = $urandom_range(5, 7);
		else cnt = $urandom_range(1, MAX_PATTERNS);

		need = 0;
		for (int i = 0; i < ((cnt > MAX_PATTERNS) ? MAX_PATTERNS : cnt); i++)
			if (hdr_off[i] + hdr_len[i] > need)
				need = hdr_off[i] + hdr_len[i];
		r = $urandom_range(0, 9);
		if (idx == 0) sp = 127;
		else if (idx == 1) sp = WINDOW_DEPTH;
		else if (r < 7) sp = (need < 1) ? 1 : (need > WINDOW_DEPTH) ? WINDOW_DEPTH : need;
		else if (r == 7) sp = 0;
		else if (r == 8) sp = $urandom_range(WINDOW_DEPTH + 1, 127);
		else sp = $urandom_range(1, WINDOW_DEPTH);

		r = $urandom_range(0, 4);
		rbase = (r == 0) ? 32'hFFFF_FFF0 - $urandom_range(0, 40) : (r == 1) ? 32'h0 : $urandom;
		r = $urandom_range(0, 9);
		if (r < 5) begin
			lo = 32'h0;
			hi = 32'hFFFF_FFFF;
		end else if (r < 8) begin
			lo = rbase + $urandom_range(0, 8);
			hi = lo + $urandom_range(0, 40);
		end else if (r == 8) begin
			lo = rbase + $urandom_range(0, 10);
			hi = lo;
		end else begin
			// empty range: begin above end
			lo = rbase + 20;
			hi = rbase;
		end
		r = $urandom_range(0, 4);
		bias = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;

		drain();
		set_config(3'(cnt), 7'(sp), lo, hi, bias);
		nscan = $urandom_range(1, 3);
		for (int i = 0; i < nscan; i++) begin
			if ($urandom_range(0, 19) == 0)
				put_end();
			run_scan(rbase + $urandom_range(0, 4));
		end
	endtask

	initial begin
		int idx;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every header written before the first memory byte
		put_pat_hdr(1, 0, 63);
		put_pat_hdr(2, 0, 0);
		put_pat_hdr(3, 0, 31);
		put_pat_byte(0, 0, 8'h41);
		put_pat_byte(0, 1, WILD_QUERY);
		put_pat_byte(0, 2, WILD_STAR);
		put_pat_byte(0, 15, 8'hFF);
		put_pat_hdr(0, 3, 0);
		drain();
		set_config(1, 3, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// start address wraps; bytes after the match give nothing, end gives nothing
		put_mem(32'hFFFF_FFFE, 8'h41, 1'b1);
		put_mem(32'hFFFF_FFFF, 8'h00, 1'b1);
		put_mem(32'h0000_0000, 8'hFF, 1'b1);
		put_mem(32'h0000_0001, 8'h41, 1'b1);
		put_end();
		// unreadable byte inside the pattern: not found
		put_mem(32'h10, 8'h41, 1'b1);
		put_mem(32'h11, 8'h00, 1'b0);
		put_mem(32'h12, 8'h00, 1'b1);
		put_end();
		drain();
		// no patterns and span zero: any readable start in range matches
		set_config(0, 0, 32'h8000_0000, 32'h8000_0000, 32'h0);
		put_mem(32'h7FFF_FFFF, 8'h00, 1'b1);
		put_mem(32'h8000_0000, 8'hAA, 1'b1);
		put_end();

		idx = 0;
		while (n_items < WORD_TARGET) begin
			run_phase(idx);
			idx++;
		end
		put_end();
		drain();

		$display("run covered %0d input words over %0d register setups", n_items, n_setups);
		$display("scans closed with %0d matches and %0d not-found reports", hit_count,
			miss_count);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
